FILE: rtl/hpm_pkg.sv
`default_nettype none

package hpm_pkg;

  localparam int CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] REG_A11_A21 = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_A31_A12 = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_A22_A32 = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_A13_A23 = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_A33     = 3'd4;

  typedef struct packed {
    logic nneg_x;
    logic nneg_y;
    logic rneg_x;
    logic rneg_y;
    logic dz;
    logic ovf_x;
    logic ovf_y;
    logic last;
  } hpm_flags_t;

endpackage

`default_nettype wire

FILE: rtl/homography_point_mapper.sv
// Projective point mapper. Each beat on the input channel carries one point
// (x_in_i, y_in_i) in signed fixed point and a last marker. The block maps it
// through the 3x3 matrix held in the configuration registers and returns one
// beat with the mapped point, a zero-denominator flag, a saturation flag and
// the copied marker. Coefficients are written through the cfg channel, which
// is always ready; the user must write them only while no point is in flight,
// which the block itself does not enforce. The pipeline registers a point
// through a stage of multipliers, then sums, then sign and magnitude, then
// quotient range check, then a row of COORD_WIDTH division cells that each
// settle one quotient bit of both coordinates, and then the output register.
// Throughput is one point per cycle while the receiver does not stall.
// Reset loads the identity matrix and empties the pipeline. When the receiver
// stalls, the output register holds its beat and the stages behind it keep
// filling empty slots, so input stays ready until every stage is occupied.
`default_nettype none

module homography_point_mapper #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [hpm_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  wire  [63:0]                          cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  signed [COORD_WIDTH-1:0]        x_in_i,
  input  wire  signed [COORD_WIDTH-1:0]        y_in_i,
  input  wire                                  last_in_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [COORD_WIDTH-1:0]        x_out_o,
  output logic signed [COORD_WIDTH-1:0]        y_out_o,
  output logic                                 zero_denominator_o,
  output logic                                 saturated_o,
  output logic                                 last_out_o
);
  import hpm_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int PW   = CW + 32;
  localparam int C0W  = 33 + FRAC_BITS;
  localparam int SW   = ((PW > C0W) ? PW : C0W) + 2;
  localparam int NW   = SW + FRAC_BITS;
  localparam int R0W  = NW - CW;
  localparam int CMPW = ((R0W > SW) ? R0W : SW) + 1;

  localparam logic [CW-1:0] MaxPos = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MinNeg = {1'b1, {(CW-1){1'b0}}};

  logic [63:0] coef0_q, coef1_q, coef2_q, coef3_q;
  logic [31:0] coef4_q;

  logic signed [31:0] a11, a21, a31, a12, a22, a32, a13, a23, a33;

  assign a11 = coef0_q[31:0];
  assign a21 = coef0_q[63:32];
  assign a31 = coef1_q[31:0];
  assign a12 = coef1_q[63:32];
  assign a22 = coef2_q[31:0];
  assign a32 = coef2_q[63:32];
  assign a13 = coef3_q[31:0];
  assign a23 = coef3_q[63:32];
  assign a33 = coef4_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef0_q <= 64'd1 << FRAC_BITS;
      coef1_q <= 64'd0;
      coef2_q <= 64'd1 << FRAC_BITS;
      coef3_q <= 64'd0;
      coef4_q <= 32'd1 << FRAC_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_A11_A21: coef0_q <= cfg_data_i;
        REG_A31_A12: coef1_q <= cfg_data_i;
        REG_A22_A32: coef2_q <= cfg_data_i;
        REG_A13_A23: coef3_q <= cfg_data_i;
        REG_A33:     coef4_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy4, rdyo, cell_in_ready;

  assign rdyo = !vo_q || out_ready_i;
  assign rdy4 = !v4_q || cell_in_ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  logic signed [PW-1:0] p11_q, p21_q, p12_q, p22_q, p13_q, p23_q;
  logic                 l1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      p11_q <= PW'(a11 * x_in_i);
      p21_q <= PW'(a21 * y_in_i);
      p12_q <= PW'(a12 * x_in_i);
      p22_q <= PW'(a22 * y_in_i);
      p13_q <= PW'(a13 * x_in_i);
      p23_q <= PW'(a23 * y_in_i);
      l1_q  <= last_in_i;
    end
  end

  logic signed [SW-1:0] nx_q, ny_q, dn_q;
  logic                 l2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      nx_q <= SW'(p11_q) + SW'(p21_q) + (SW'(a31) <<< FRAC_BITS);
      ny_q <= SW'(p12_q) + SW'(p22_q) + (SW'(a32) <<< FRAC_BITS);
      dn_q <= SW'(p13_q) + SW'(p23_q) + (SW'(a33) <<< FRAC_BITS);
      l2_q <= l1_q;
    end
  end

  logic [SW-1:0] nxm_q, nym_q, dm3_q;
  hpm_flags_t    f3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      nxm_q       <= nx_q[SW-1] ? SW'(-nx_q) : SW'(nx_q);
      nym_q       <= ny_q[SW-1] ? SW'(-ny_q) : SW'(ny_q);
      dm3_q       <= dn_q[SW-1] ? SW'(-dn_q) : SW'(dn_q);
      f3_q.nneg_x <= nx_q[SW-1];
      f3_q.nneg_y <= ny_q[SW-1];
      f3_q.rneg_x <= nx_q[SW-1] ^ dn_q[SW-1];
      f3_q.rneg_y <= ny_q[SW-1] ^ dn_q[SW-1];
      f3_q.dz     <= (dn_q == '0);
      f3_q.ovf_x  <= 1'b0;
      f3_q.ovf_y  <= 1'b0;
      f3_q.last   <= l2_q;
    end
  end

  logic [NW-1:0]  numx, numy;
  logic [R0W-1:0] r0x, r0y;
  hpm_flags_t     f4_d;

  always_comb begin
    numx       = {nxm_q, {FRAC_BITS{1'b0}}};
    numy       = {nym_q, {FRAC_BITS{1'b0}}};
    r0x        = numx[NW-1:CW];
    r0y        = numy[NW-1:CW];
    f4_d       = f3_q;
    f4_d.ovf_x = CMPW'(r0x) >= CMPW'(dm3_q);
    f4_d.ovf_y = CMPW'(r0y) >= CMPW'(dm3_q);
  end

  logic [SW-1:0] dm4_q, rx4_q, ry4_q;
  logic [CW-1:0] lx4_q, ly4_q;
  hpm_flags_t    f4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      dm4_q <= dm3_q;
      rx4_q <= SW'(r0x);
      ry4_q <= SW'(r0y);
      lx4_q <= numx[CW-1:0];
      ly4_q <= numy[CW-1:0];
      f4_q  <= f4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  logic [SW-1:0] c_dm [0:CW];
  logic [SW-1:0] c_rx [0:CW];
  logic [SW-1:0] c_ry [0:CW];
  logic [CW-1:0] c_lx [0:CW];
  logic [CW-1:0] c_ly [0:CW];
  logic [CW-1:0] c_qx [0:CW];
  logic [CW-1:0] c_qy [0:CW];
  hpm_flags_t    c_f  [0:CW];
  logic          c_v  [0:CW];
  logic          c_r  [0:CW];

  assign c_dm[0] = dm4_q;
  assign c_rx[0] = rx4_q;
  assign c_ry[0] = ry4_q;
  assign c_lx[0] = lx4_q;
  assign c_ly[0] = ly4_q;
  assign c_qx[0] = '0;
  assign c_qy[0] = '0;
  assign c_f[0]  = f4_q;
  assign c_v[0]  = v4_q;
  assign cell_in_ready = c_r[0];
  assign c_r[CW] = rdyo;

  for (genvar i = 0; i < CW; i++) begin : g_cell
    hpm_div_cell #(
      .RW(SW),
      .QW(CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (c_v[i]),
      .in_ready_o (c_r[i]),
      .dm_i       (c_dm[i]),
      .rx_i       (c_rx[i]),
      .ry_i       (c_ry[i]),
      .lx_i       (c_lx[i]),
      .ly_i       (c_ly[i]),
      .qx_i       (c_qx[i]),
      .qy_i       (c_qy[i]),
      .flags_i    (c_f[i]),
      .out_valid_o(c_v[i+1]),
      .out_ready_i(c_r[i+1]),
      .dm_o       (c_dm[i+1]),
      .rx_o       (c_rx[i+1]),
      .ry_o       (c_ry[i+1]),
      .lx_o       (c_lx[i+1]),
      .ly_o       (c_ly[i+1]),
      .qx_o       (c_qx[i+1]),
      .qy_o       (c_qy[i+1]),
      .flags_o    (c_f[i+1])
    );
  end

  hpm_flags_t    fe;
  logic [CW-1:0] limx, limy, mx, my, xv, yv;
  logic          satx, saty;

  always_comb begin
    fe   = c_f[CW];
    limx = fe.rneg_x ? MinNeg : MaxPos;
    limy = fe.rneg_y ? MinNeg : MaxPos;
    satx = fe.ovf_x || (c_qx[CW] > limx);
    saty = fe.ovf_y || (c_qy[CW] > limy);
    mx   = satx ? limx : c_qx[CW];
    my   = saty ? limy : c_qy[CW];
    if (fe.dz) begin
      xv = fe.nneg_x ? MinNeg : MaxPos;
      yv = fe.nneg_y ? MinNeg : MaxPos;
    end else begin
      xv = fe.rneg_x ? CW'(-mx) : mx;
      yv = fe.rneg_y ? CW'(-my) : my;
    end
  end

  logic [CW-1:0] xo_q, yo_q;
  logic          zo_q, so_q, lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdyo) begin
      vo_q <= c_v[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyo && c_v[CW]) begin
      xo_q <= xv;
      yo_q <= yv;
      zo_q <= fe.dz;
      so_q <= !fe.dz && (satx || saty);
      lo_q <= fe.last;
    end
  end

  assign out_valid_o        = vo_q;
  assign x_out_o            = xo_q;
  assign y_out_o            = yo_q;
  assign zero_denominator_o = zo_q;
  assign saturated_o        = so_q;
  assign last_out_o         = lo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_denominator_o |-> !saturated_o)
    else $error("Saturation flagged together with a zero denominator.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_denominator_o |->
      (x_out_o == MaxPos || x_out_o == MinNeg) && (y_out_o == MaxPos || y_out_o == MinNeg))
    else $error("Zero-denominator beat carries an unsaturated coordinate.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && v4_q && vo_q)
    else $error("Input stalled while the pipeline has an empty slot.");

endmodule

`default_nettype wire

FILE: rtl/hpm_div_cell.sv
`default_nettype none

module hpm_div_cell #(
  parameter int RW = 66,
  parameter int QW = 32
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire  [RW-1:0]           dm_i,
  input  wire  [RW-1:0]           rx_i,
  input  wire  [RW-1:0]           ry_i,
  input  wire  [QW-1:0]           lx_i,
  input  wire  [QW-1:0]           ly_i,
  input  wire  [QW-1:0]           qx_i,
  input  wire  [QW-1:0]           qy_i,
  input  hpm_pkg::hpm_flags_t     flags_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic [RW-1:0]           dm_o,
  output logic [RW-1:0]           rx_o,
  output logic [RW-1:0]           ry_o,
  output logic [QW-1:0]           lx_o,
  output logic [QW-1:0]           ly_o,
  output logic [QW-1:0]           qx_o,
  output logic [QW-1:0]           qy_o,
  output hpm_pkg::hpm_flags_t     flags_o
);
  import hpm_pkg::*;

  logic            valid_q, valid_d;
  logic [RW:0]     tx, ty;
  logic            gex, gey;
  logic [RW-1:0]   nrx, nry;
  logic [RW-1:0]   dm_q, rx_q, ry_q;
  logic [QW-1:0]   lx_q, ly_q, qx_q, qy_q;
  hpm_flags_t      flags_q;
  logic            load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_ready_o && in_valid_i;

  always_comb begin
    tx  = {rx_i, lx_i[QW-1]};
    ty  = {ry_i, ly_i[QW-1]};
    gex = tx >= {1'b0, dm_i};
    gey = ty >= {1'b0, dm_i};
    nrx = gex ? RW'(tx - {1'b0, dm_i}) : tx[RW-1:0];
    nry = gey ? RW'(ty - {1'b0, dm_i}) : ty[RW-1:0];
  end

  always_comb begin
    valid_d = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dm_q    <= dm_i;
      rx_q    <= nrx;
      ry_q    <= nry;
      lx_q    <= {lx_i[QW-2:0], 1'b0};
      ly_q    <= {ly_i[QW-2:0], 1'b0};
      qx_q    <= {qx_i[QW-2:0], gex};
      qy_q    <= {qy_i[QW-2:0], gey};
      flags_q <= flags_i;
    end
  end

  assign out_valid_o = valid_q;
  assign dm_o        = dm_q;
  assign rx_o        = rx_q;
  assign ry_o        = ry_q;
  assign lx_o        = lx_q;
  assign ly_o        = ly_q;
  assign qx_o        = qx_q;
  assign qy_o        = qy_q;
  assign flags_o     = flags_q;

endmodule

`default_nettype wire
